[src/wpwr_pkg.sv]
// Shared types, widths and codes for the weighted pick without replacement block.
// No dependencies; every other file takes its names from here by scoped reference.
`timescale 1ns / 1ps
`default_nettype none

package wpwr_pkg;

  // Field widths of the input and result beats.
  localparam int CMD_W       = 2;
  localparam int VALUE_W     = 64;
  localparam int WEIGHT_IN_W = 32;
  localparam int CUTOFF_W    = 38;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_OUT_W = 38;
  localparam int COUNT_OUT_W = 7;

  // Default sizing of the entry table.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int WEIGHT_BITS_DEF = 32;

  // Command codes carried by an input beat; the spare code leaves the table alone and reports success.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_e;

  // Status codes carried by a result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear;       // empty the table
    logic    load;        // append the input entry
    logic    draw_start;  // latch the cutoff and read entry zero
    logic    scan_step;   // subtract the current weight and read the next entry
    logic    scan_hit;    // record the hit and read the last entry
    logic    commit;      // move the last entry into the hit slot
    logic    set_result;  // capture the result of this item
    status_e result;      // status to capture
    logic    publish;     // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic out_of_range;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/wpwr_in_if.sv]
// Input channel of the weighted pick block: valid, ready and one command beat.
// Depends on wpwr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wpwr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [wpwr_pkg::CMD_W-1:0]       command;
  logic signed [wpwr_pkg::VALUE_W-1:0]     value;
  logic        [wpwr_pkg::WEIGHT_IN_W-1:0] weight;
  logic        [wpwr_pkg::CUTOFF_W-1:0]    cutoff;

  modport source (output valid, command, value, weight, cutoff, input ready);
  modport sink (input valid, command, value, weight, cutoff, output ready);
endinterface

`default_nettype wire

[src/wpwr_out_if.sv]
// Result channel of the weighted pick block: valid, ready and one result beat.
// Depends on wpwr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wpwr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [wpwr_pkg::STATUS_W-1:0]    status;
  logic signed [wpwr_pkg::VALUE_W-1:0]     picked_value;
  logic        [wpwr_pkg::TOTAL_OUT_W-1:0] total_weight;
  logic        [wpwr_pkg::COUNT_OUT_W-1:0] entries_left;

  modport source (output valid, status, picked_value, total_weight, entries_left, input ready);
  modport sink (input valid, status, picked_value, total_weight, entries_left, output ready);
endinterface

`default_nettype wire

[src/wpwr_ctrl.sv]
// Controller of the weighted pick block: sequences clear, load and draw items.
// Depends on wpwr_pkg for the command, status and control struct types.
`timescale 1ns / 1ps
`default_nettype none

module wpwr_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  input  wire [wpwr_pkg::CMD_W-1:0]   command_i,
  output logic                        in_ready_o,
  input  wpwr_pkg::dp_stat_t          stat_i,
  output wpwr_pkg::dp_cmd_t           cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  // Next state and the datapath commands for the current cycle.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d          = S_RESP;
          cmd_o.set_result = 1'b1;
          cmd_o.result     = wpwr_pkg::ST_OK;
          case (wpwr_pkg::cmd_e'(command_i))
            wpwr_pkg::CMD_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            wpwr_pkg::CMD_LOAD: begin
              if (stat_i.full) begin
                cmd_o.result = wpwr_pkg::ST_FULL;
              end else begin
                cmd_o.load = 1'b1;
              end
            end
            wpwr_pkg::CMD_DRAW: begin
              if (stat_i.empty) begin
                cmd_o.result = wpwr_pkg::ST_EMPTY;
              end else if (stat_i.out_of_range) begin
                cmd_o.result = wpwr_pkg::ST_RANGE;
              end else begin
                cmd_o.set_result = 1'b0;
                cmd_o.draw_start = 1'b1;
                state_d          = S_SCAN;
              end
            end
            default: begin
              // The spare code leaves the table alone and reports success.
              cmd_o.result = wpwr_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        // One stored entry is checked per cycle until the cutoff lands in one.
        if (stat_i.hit) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = S_LAST;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_LAST: begin
        cmd_o.commit     = 1'b1;
        cmd_o.set_result = 1'b1;
        cmd_o.result     = wpwr_pkg::ST_OK;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/wpwr_dp.sv]
// Datapath of the weighted pick block: entry memory, running total, scan and output register.
// Depends on wpwr_pkg; driven by wpwr_ctrl through the dp_cmd_t struct.
`timescale 1ns / 1ps
`default_nettype none

module wpwr_dp #(
  parameter int MAX_ENTRIES = wpwr_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wpwr_pkg::WEIGHT_BITS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wpwr_pkg::dp_cmd_t                     cmd_i,
  output wpwr_pkg::dp_stat_t                    stat_o,
  input  wire signed [wpwr_pkg::VALUE_W-1:0]     value_i,
  input  wire        [wpwr_pkg::WEIGHT_IN_W-1:0] weight_i,
  input  wire        [wpwr_pkg::CUTOFF_W-1:0]    cutoff_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic       [wpwr_pkg::STATUS_W-1:0]    status_o,
  output logic signed [wpwr_pkg::VALUE_W-1:0]    picked_value_o,
  output logic       [wpwr_pkg::TOTAL_OUT_W-1:0] total_weight_o,
  output logic       [wpwr_pkg::COUNT_OUT_W-1:0] entries_left_o
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int WW   = (WEIGHT_BITS < wpwr_pkg::WEIGHT_IN_W) ? WEIGHT_BITS
                                                              : wpwr_pkg::WEIGHT_IN_W;
  localparam int TW   = WW + AW;
  localparam int CMPW = (TW > wpwr_pkg::CUTOFF_W) ? TW : wpwr_pkg::CUTOFF_W;
  localparam int VW   = wpwr_pkg::VALUE_W;
  localparam int CTW  = wpwr_pkg::CUTOFF_W;

  // Entry memory, one write and one registered read per cycle.
  logic [VW-1:0] value_mem  [MAX_ENTRIES];
  logic [WW-1:0] weight_mem [MAX_ENTRIES];
  logic [VW-1:0] rd_value_q;
  logic [WW-1:0] rd_weight_q;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr, last_idx;
  logic [VW-1:0] wr_value;
  logic [WW-1:0] wr_weight;

  // Table state and scan registers.
  logic [CW-1:0]  count_q;
  logic [TW-1:0]  total_q;
  logic [CTW-1:0] cut_q;
  logic [AW-1:0]  idx_q, hit_idx_q;
  logic [WW-1:0]  hit_w_q;
  logic [VW-1:0]  pick_q;
  wpwr_pkg::status_e res_status_q;
  logic [VW-1:0]  res_value_q;

  // Output register.
  logic                             out_valid_q;
  logic [wpwr_pkg::STATUS_W-1:0]    out_status_q;
  logic [VW-1:0]                    out_value_q;
  logic [wpwr_pkg::TOTAL_OUT_W-1:0] out_total_q;
  logic [wpwr_pkg::COUNT_OUT_W-1:0] out_count_q;

  // Memory addressing: a load appends, a commit moves the last entry into the hit slot.
  assign last_idx  = AW'(count_q - CW'(1));
  assign wr_en     = cmd_i.load | cmd_i.commit;
  assign wr_addr   = cmd_i.commit ? hit_idx_q : count_q[AW-1:0];
  assign wr_value  = cmd_i.commit ? rd_value_q : value_i;
  assign wr_weight = cmd_i.commit ? rd_weight_q : weight_i[WW-1:0];
  assign rd_en     = cmd_i.draw_start | cmd_i.scan_step | cmd_i.scan_hit;

  always_comb begin
    if (cmd_i.draw_start) begin
      rd_addr = '0;
    end else if (cmd_i.scan_step) begin
      rd_addr = idx_q + AW'(1);
    end else begin
      rd_addr = last_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      value_mem[wr_addr]  <= wr_value;
      weight_mem[wr_addr] <= wr_weight;
    end
    if (rd_en) begin
      rd_value_q  <= value_mem[rd_addr];
      rd_weight_q <= weight_mem[rd_addr];
    end
  end

  // Entry count and running total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      total_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_q + CW'(1);
      total_q <= total_q + TW'(weight_i[WW-1:0]);
    end else if (cmd_i.commit) begin
      count_q <= count_q - CW'(1);
      total_q <= total_q - TW'(hit_w_q);
    end
  end

  // Scan: the remaining cutoff loses each weight it passes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_start) begin
      cut_q <= cutoff_i;
      idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      cut_q <= cut_q - CTW'(rd_weight_q);
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.scan_hit) begin
      hit_idx_q <= idx_q;
      hit_w_q   <= rd_weight_q;
      pick_q    <= rd_value_q;
    end
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.result;
      res_value_q  <= cmd_i.commit ? pick_q : '0;
    end
  end

  // Result beat holds until taken; a new one may replace it in the cycle it leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_total_q  <= wpwr_pkg::TOTAL_OUT_W'(total_q);
      out_count_q  <= wpwr_pkg::COUNT_OUT_W'(count_q);
    end
  end

  // Status toward the controller.
  assign stat_o.full         = (count_q >= CW'(MAX_ENTRIES));
  assign stat_o.empty        = (count_q == '0) || (total_q == '0);
  assign stat_o.out_of_range = (CMPW'(cutoff_i) >= CMPW'(total_q));
  assign stat_o.hit          = (cut_q < CTW'(rd_weight_q));
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign picked_value_o = out_value_q;
  assign total_weight_o = out_total_q;
  assign entries_left_o = out_count_q;

endmodule

`default_nettype wire

[src/weighted_pick_without_replacement.sv]
// Weighted pick without replacement: a table of value and weight pairs with one draw per item.
// Usage:
//   in_i carries one command beat: clear the table, load one value and weight pair, or draw
//   one entry with a cutoff below the current total weight. out_o returns one result beat for
//   every command: a status code, the picked value (zero unless a draw succeeds), the total
//   weight that remains and the number of entries held, so the requester can scale its next
//   random cutoff.
//   Clear, load, error and spare commands capture their result when accepted and then publish it.
//   A draw scans the entry memory from entry zero, one entry per cycle, until the cutoff
//   lands in an entry; then the last entry is read and written into the freed slot.
//   One item is in work at a time; in_i.ready is high whenever the block is idle, also while
//   an earlier result still waits in the output register.
//   If the receiver stalls, the result beat holds in the output register and the next item
//   finishes its work, then waits until that register is free.
//   Reset empties the table and clears the total; the entry memory itself is not cleared
//   and is only read at entries that a load has written.
// Depends on wpwr_pkg, wpwr_in_if, wpwr_out_if, wpwr_ctrl and wpwr_dp.
`timescale 1ns / 1ps
`default_nettype none

module weighted_pick_without_replacement #(
  parameter int MAX_ENTRIES = wpwr_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wpwr_pkg::WEIGHT_BITS_DEF
) (
  input wire         clk_i,
  input wire         rst_ni,
  wpwr_in_if.sink    in_i,
  wpwr_out_if.source out_o
);

  wpwr_pkg::dp_cmd_t  cmd;
  wpwr_pkg::dp_stat_t stat;

  // Local copies of the channel handshakes and result beat.
  logic                                 in_valid, in_ready;
  logic                                 out_valid, out_ready;
  logic        [wpwr_pkg::STATUS_W-1:0]    out_status;
  logic signed [wpwr_pkg::VALUE_W-1:0]     out_picked;
  logic        [wpwr_pkg::TOTAL_OUT_W-1:0] out_total;
  logic        [wpwr_pkg::COUNT_OUT_W-1:0] out_entries;

  assign in_valid           = in_i.valid;
  assign in_i.ready         = in_ready;
  assign out_ready          = out_o.ready;
  assign out_o.valid        = out_valid;
  assign out_o.status       = out_status;
  assign out_o.picked_value = out_picked;
  assign out_o.total_weight = out_total;
  assign out_o.entries_left = out_entries;

  // Sequencer.
  wpwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .command_i  (in_i.command),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, scan and output register.
  wpwr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_i        (in_i.value),
    .weight_i       (in_i.weight),
    .cutoff_i       (in_i.cutoff),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (out_status),
    .picked_value_o (out_picked),
    .total_weight_o (out_total),
    .entries_left_o (out_entries)
  );

endmodule

`default_nettype wire

[src/wpwr_checker.sv]
// Port-level checks for the weighted pick block, bound to its top level.
// Depends on wpwr_pkg for the status codes and on the top level's local port copies.
`timescale 1ns / 1ps
`default_nettype none

module wpwr_checker #(
  parameter int MAX_ENTRIES = wpwr_pkg::MAX_ENTRIES_DEF
) (
  input wire                                   clk_i,
  input wire                                   rst_ni,
  input wire                                   in_valid_i,
  input wire                                   in_ready_i,
  input wire                                   out_valid_i,
  input wire                                   out_ready_i,
  input wire        [wpwr_pkg::STATUS_W-1:0]    out_status_i,
  input wire signed [wpwr_pkg::VALUE_W-1:0]     out_picked_i,
  input wire        [wpwr_pkg::TOTAL_OUT_W-1:0] out_total_i,
  input wire        [wpwr_pkg::COUNT_OUT_W-1:0] out_entries_i
);

  // One item at a time: an accepted beat closes the input until its result is made.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item was in work");

  // A waiting result beat is not dropped.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Only a successful draw carries a picked value.
  a_pick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != wpwr_pkg::ST_OK) |-> (out_picked_i == '0))
    else $error("picked value nonzero on an error status");

  // A full report means the table holds its maximum.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == wpwr_pkg::ST_FULL)
      |-> (out_entries_i == wpwr_pkg::COUNT_OUT_W'(MAX_ENTRIES)))
    else $error("full status with a table that is not full");

  // An empty report means no entries or no weight are left.
  a_empty_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == wpwr_pkg::ST_EMPTY)
      |-> (out_entries_i == '0) || (out_total_i == '0))
    else $error("empty status with entries and weight left");

endmodule

bind weighted_pick_without_replacement wpwr_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_wpwr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid),
  .in_ready_i    (in_ready),
  .out_valid_i   (out_valid),
  .out_ready_i   (out_ready),
  .out_status_i  (out_status),
  .out_picked_i  (out_picked),
  .out_total_i   (out_total),
  .out_entries_i (out_entries)
);

`default_nettype wire
